@@ hdl/olt_pkg.sv @@
// Package for the ordered value list table.
// Holds command codes, request/response structs and the sequencer state type.
// No dependencies.
package olt_pkg;

  // Command codes carried in req_t.cmd
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REM_EQ = 3'd1;
  localparam logic [2:0] CMD_REM_GT = 3'd2;
  localparam logic [2:0] CMD_REM_LT = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [VALUE_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       dropped;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_t;

endpackage

@@ hdl/ordered_value_list_table.sv @@
// Ordered value list table: a list of signed 32-bit values, newest at the front, up to
// CAPACITY entries, kept in one RAM and worked on by a sequencer around one shared
// comparator. A request is taken when start is high and busy is low; busy then stays
// high until the single result has been shown on rsp for one cycle with done high. The
// receiver cannot stall and must take the result in that cycle. An insert moves each older
// entry back by one place, from the tail toward the front, through the single RAM read and
// write port, one read and one write per entry, then puts the new value at the front; an
// insert into a full list changes nothing and reports dropped. A query scans from the front
// and stops at the first match or at the end of the list. A removal scans to the first
// match and then moves every later entry forward by one place. Any search of an empty
// list and unused command codes complete without a scan and change nothing.
// Depends on olt_pkg, olt_ram and olt_cmp.
module ordered_value_list_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  olt_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output olt_pkg::rsp_t rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  olt_pkg::state_t state, state_next;

  logic [2:0]                         cmd_q, cmd_q_next;
  logic signed [olt_pkg::VALUE_W-1:0] key, key_next;
  logic [CW-1:0]                      cnt, cnt_next;
  logic [CW-1:0]                      idx, idx_next;
  logic                               hit_q, hit_q_next;
  logic                               drop_q, drop_q_next;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [AW-1:0]                      ram_raddr;
  logic [olt_pkg::VALUE_W-1:0]        ram_wdata;
  logic [olt_pkg::VALUE_W-1:0]        ram_rdata;
  logic                               match;

  logic [CW:0]                        idx_p1;
  logic [CW:0]                        idx_p2;
  logic [CW:0]                        cnt_w;

  assign idx_p1 = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx} + (CW+1)'(2);
  assign cnt_w  = {1'b0, cnt};

  olt_ram #(
    .WIDTH (olt_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  olt_cmp u_cmp (
    .cmd    (cmd_q),
    .stored (ram_rdata),
    .key    (key),
    .match  (match)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= olt_pkg::ST_IDLE;
      cnt    <= '0;
      hit_q  <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      hit_q  <= hit_q_next;
      drop_q <= drop_q_next;
    end
  end

  // Request payload and position register
  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    key   <= key_next;
    idx   <= idx_next;
  end

  // Sequencer: next state, RAM control and outputs
  always_comb begin
    state_next  = state;
    cmd_q_next  = cmd_q;
    key_next    = key;
    cnt_next    = cnt;
    idx_next    = idx;
    hit_q_next  = hit_q;
    drop_q_next = drop_q;
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx[AW-1:0];
    busy        = 1'b1;
    done        = 1'b0;

    unique case (state)
      olt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_q_next  = req.cmd;
          key_next    = req.operand;
          hit_q_next  = 1'b0;
          drop_q_next = 1'b0;
          idx_next    = '0;
          case (req.cmd)
            olt_pkg::CMD_INSERT: begin
              if (cnt == CW'(CAPACITY)) begin
                drop_q_next = 1'b1;
                state_next  = olt_pkg::ST_DONE;
              end else if (cnt == '0) begin
                state_next = olt_pkg::ST_INS_PUT;
              end else begin
                idx_next   = cnt - CW'(1);
                state_next = olt_pkg::ST_INS_RD;
              end
            end
            olt_pkg::CMD_REM_EQ, olt_pkg::CMD_REM_GT, olt_pkg::CMD_REM_LT,
            olt_pkg::CMD_QUERY: begin
              state_next = (cnt == '0) ? olt_pkg::ST_DONE : olt_pkg::ST_SRCH_RD;
            end
            default: state_next = olt_pkg::ST_DONE;
          endcase
        end
      end

      // Move entry idx back to idx+1, from the tail toward the front
      olt_pkg::ST_INS_RD: begin
        state_next = olt_pkg::ST_INS_WR;
      end
      olt_pkg::ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_p1[AW-1:0];
        if (idx == '0) begin
          state_next = olt_pkg::ST_INS_PUT;
        end else begin
          idx_next   = idx - CW'(1);
          state_next = olt_pkg::ST_INS_RD;
        end
      end
      olt_pkg::ST_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = key;
        cnt_next   = cnt + CW'(1);
        state_next = olt_pkg::ST_DONE;
      end

      // Scan from the front through the shared comparator
      olt_pkg::ST_SRCH_RD: begin
        state_next = olt_pkg::ST_SRCH_CMP;
      end
      olt_pkg::ST_SRCH_CMP: begin
        if (match) begin
          hit_q_next = 1'b1;
          if (cmd_q == olt_pkg::CMD_QUERY) begin
            state_next = olt_pkg::ST_DONE;
          end else if (idx_p1 < cnt_w) begin
            state_next = olt_pkg::ST_SH_RD;
          end else begin
            cnt_next   = cnt - CW'(1);
            state_next = olt_pkg::ST_DONE;
          end
        end else if (idx_p1 < cnt_w) begin
          idx_next   = idx_p1[CW-1:0];
          state_next = olt_pkg::ST_SRCH_RD;
        end else begin
          state_next = olt_pkg::ST_DONE;
        end
      end

      // Close the gap: move entry idx+1 forward to idx
      olt_pkg::ST_SH_RD: begin
        ram_raddr  = idx_p1[AW-1:0];
        state_next = olt_pkg::ST_SH_WR;
      end
      olt_pkg::ST_SH_WR: begin
        ram_we = 1'b1;
        if (idx_p2 < cnt_w) begin
          idx_next   = idx_p1[CW-1:0];
          state_next = olt_pkg::ST_SH_RD;
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = olt_pkg::ST_DONE;
        end
      end

      olt_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = olt_pkg::ST_IDLE;
      end

      default: state_next = olt_pkg::ST_IDLE;
    endcase
  end

  // Result fields
  assign rsp.hit         = hit_q;
  assign rsp.entry_count = 5'(cnt);
  assign rsp.is_empty    = (cnt == '0);
  assign rsp.dropped     = drop_q;

  // Result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // Count never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A dropped insert never reports a hit
  a_drop_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.dropped) |-> !rsp.hit)
    else $error("dropped insert reported a hit");

endmodule

@@ hdl/olt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/olt_cmp.sv @@
// Shared signed compare unit for the ordered value list table.
// Decides whether a stored value matches the key under the current command.
// Depends on olt_pkg.
module olt_cmp (
  input  logic [2:0]                         cmd,
  input  logic signed [olt_pkg::VALUE_W-1:0] stored,
  input  logic signed [olt_pkg::VALUE_W-1:0] key,
  output logic                               match
);

  // Select the relation that the command asks for
  always_comb begin
    case (cmd)
      olt_pkg::CMD_REM_EQ, olt_pkg::CMD_QUERY: match = (stored == key);
      olt_pkg::CMD_REM_GT:                     match = (stored > key);
      default:                                 match = (stored < key);
    endcase
  end

endmodule
